[hdl/vertex_to_screen_projection_defines.svh]
// Assertion macros for the vertex projection block.
// Needs a clock named clock and a reset named reset in the including module.
`ifndef VERTEX_TO_SCREEN_PROJECTION_DEFINES_SVH
`define VERTEX_TO_SCREEN_PROJECTION_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define VTSP_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define VTSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/vtsp_pkg.sv]
// Shared constants, register codes and sideband type for the vertex projection.
// No dependencies.
package vtsp_pkg;

   localparam int SCREEN_WIDTH  = 640;
   localparam int SCREEN_HEIGHT = 480;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_COS_FIRST  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SIN_FIRST  = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_COS_SECOND = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SIN_SECOND = 8'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET_X   = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET_Y   = 8'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET_Z   = 8'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_FOCAL      = 8'd7;

   // Divider geometry: numerator focal*|v| + |z|/2, denominator |z|.
   localparam int DIV_NUM_W  = 64;
   localparam int DIV_DEN_W  = 39;
   localparam int DIV_STAGES = DIV_NUM_W;

   // Pipeline stages ahead of the divider, and accept-to-strobe latency.
   localparam int PRE_STAGES = 7;
   localparam int LATENCY    = PRE_STAGES + DIV_STAGES + 1;

   typedef struct packed {
      logic        zero;
      logic        neg_x;
      logic        neg_y;
      logic        dz_sat;
      logic [31:0] dz;
   } side_type;

endpackage

[hdl/vtsp_div.sv]
// Pipelined restoring divider, two numerators over one shared denominator.
// Depends on vtsp_pkg; one quotient bit per stage, sideband carried along.
module vtsp_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [vtsp_pkg::DIV_NUM_W-1:0] in_num_x,
   input  logic [vtsp_pkg::DIV_NUM_W-1:0] in_num_y,
   input  logic [vtsp_pkg::DIV_DEN_W-1:0] in_den,
   input  vtsp_pkg::side_type             in_side,
   output logic                          out_valid,
   output logic [vtsp_pkg::DIV_NUM_W-1:0] out_q_x,
   output logic [vtsp_pkg::DIV_NUM_W-1:0] out_q_y,
   output vtsp_pkg::side_type             out_side
);
   import vtsp_pkg::*;

   typedef struct packed {
      logic [DIV_DEN_W-1:0] rem;
      logic [DIV_NUM_W-1:0] num;
   } step_type;

   // Numerator shifts out at the top, quotient bits shift in at the bottom.
   function automatic step_type div_step(input logic [DIV_DEN_W-1:0] rem,
                                         input logic [DIV_NUM_W-1:0] num,
                                         input logic [DIV_DEN_W-1:0] den);
      logic [DIV_DEN_W:0] t;
      logic               ge;
      step_type           r;
      t  = {rem, num[DIV_NUM_W-1]};
      ge = (t >= {1'b0, den});
      r.rem = ge ? DIV_DEN_W'(t - {1'b0, den}) : t[DIV_DEN_W-1:0];
      r.num = {num[DIV_NUM_W-2:0], ge};
      return r;
   endfunction

   logic                 valid_ff [DIV_STAGES];
   logic [DIV_DEN_W-1:0] rem_x_ff [DIV_STAGES];
   logic [DIV_DEN_W-1:0] rem_y_ff [DIV_STAGES];
   logic [DIV_NUM_W-1:0] num_x_ff [DIV_STAGES];
   logic [DIV_NUM_W-1:0] num_y_ff [DIV_STAGES];
   logic [DIV_DEN_W-1:0] den_ff   [DIV_STAGES];
   side_type             side_ff  [DIV_STAGES];

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
      logic                 v_src;
      logic [DIV_DEN_W-1:0] rx_src, ry_src, d_src;
      logic [DIV_NUM_W-1:0] nx_src, ny_src;
      side_type             s_src;
      step_type             step_x, step_y;

      if (i == 0) begin : g_first
         assign v_src  = in_valid;
         assign rx_src = '0;
         assign ry_src = '0;
         assign nx_src = in_num_x;
         assign ny_src = in_num_y;
         assign d_src  = in_den;
         assign s_src  = in_side;
      end else begin : g_next
         assign v_src  = valid_ff[i-1];
         assign rx_src = rem_x_ff[i-1];
         assign ry_src = rem_y_ff[i-1];
         assign nx_src = num_x_ff[i-1];
         assign ny_src = num_y_ff[i-1];
         assign d_src  = den_ff[i-1];
         assign s_src  = side_ff[i-1];
      end

      assign step_x = div_step(rx_src, nx_src, d_src);
      assign step_y = div_step(ry_src, ny_src, d_src);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= v_src;
         end
         rem_x_ff[i] <= step_x.rem;
         rem_y_ff[i] <= step_y.rem;
         num_x_ff[i] <= step_x.num;
         num_y_ff[i] <= step_y.num;
         den_ff[i]   <= d_src;
         side_ff[i]  <= s_src;
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_q_x   = num_x_ff[DIV_STAGES-1];
   assign out_q_y   = num_y_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];

endmodule

[hdl/vertex_to_screen_projection.sv]
// Top level of the perspective vertex projection pipeline.
// Depends on vtsp_pkg, vtsp_div and vertex_to_screen_projection_defines.svh.
//
// Usage:
//   Input: one vertex beat (req_vertex_x/y/z, Q16.16) is taken at each clock
//   edge with start high and busy low. busy is always low: the pipeline
//   advances every cycle, so a vertex may be offered in every cycle.
//   Output: each result beat appears on the rsp_ ports for one cycle with
//   rsp_valid high. The receiver cannot stall, so nothing here ever waits
//   on it; results leave in input order.
//   Throughput: one vertex per cycle. Pipeline: 7 arithmetic stages
//   (rotation, offset, abs, focal multiply), then 64 divider stages, one
//   quotient bit each, then 1 output stage for centering and saturation.
//   Config: csr_ready is always high; a beat with csr_valid writes register
//   csr_index. Indexes past the focal register are dropped. Write only while
//   no vertex is in flight.
//   Reset (synchronous): clears all stage valid bits and loads the identity
//   rotation, zero offsets and the default focal scale.
//   Zero depth: result is the screen center, depth 0, invalid_flag set.
module vertex_to_screen_projection (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic signed [31:0]               req_vertex_x,
   input  logic signed [31:0]               req_vertex_y,
   input  logic signed [31:0]               req_vertex_z,
   output logic                             rsp_valid,
   output logic signed [31:0]               rsp_screen_x,
   output logic signed [31:0]               rsp_screen_y,
   output logic signed [31:0]               rsp_view_depth,
   output logic                             rsp_invalid_flag,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [vtsp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [vtsp_pkg::CSR_DATA_W-1:0]  csr_data
);
   import vtsp_pkg::*;
`include "vertex_to_screen_projection_defines.svh"

   localparam logic signed [65:0] CENTER_X = 66'(SCREEN_WIDTH * 128);
   localparam logic signed [65:0] CENTER_Y = 66'(SCREEN_HEIGHT * 128);

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // ---------------- configuration registers ----------------
   logic signed [15:0] cos1_ff, sin1_ff, cos2_ff, sin2_ff;
   logic signed [31:0] offset_x_ff, offset_y_ff, offset_z_ff;
   logic        [23:0] focal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos1_ff     <= 16'sd16384;
         sin1_ff     <= '0;
         cos2_ff     <= 16'sd16384;
         sin2_ff     <= '0;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         offset_z_ff <= '0;
         focal_ff    <= 24'd61440;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_COS_FIRST:  cos1_ff     <= csr_data[15:0];
            REG_SIN_FIRST:  sin1_ff     <= csr_data[15:0];
            REG_COS_SECOND: cos2_ff     <= csr_data[15:0];
            REG_SIN_SECOND: sin2_ff     <= csr_data[15:0];
            REG_OFFSET_X:   offset_x_ff <= csr_data;
            REG_OFFSET_Y:   offset_y_ff <= csr_data;
            REG_OFFSET_Z:   offset_z_ff <= csr_data;
            REG_FOCAL:      focal_ff    <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   // ---------------- stage 1: first-angle (Ry) products ----------------
   logic               v1_ff;
   logic signed [47:0] p_c1x_ff, p_s1z_ff, p_c1z_ff, p_s1x_ff;
   logic signed [31:0] y1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= start && !busy;
      p_c1x_ff <= cos1_ff * req_vertex_x;
      p_s1z_ff <= sin1_ff * req_vertex_z;
      p_c1z_ff <= cos1_ff * req_vertex_z;
      p_s1x_ff <= sin1_ff * req_vertex_x;
      y1_ff    <= req_vertex_y;
   end

   // ---------------- stage 2: round Q30 -> Q16 ----------------
   logic               v2_ff;
   logic signed [34:0] tx_ff, tz_ff;
   logic signed [31:0] ty_ff;
   logic signed [48:0] sum_tx, sum_tz;

   assign sum_tx = 49'(p_c1x_ff) + 49'(p_s1z_ff) + 49'sd8192;
   assign sum_tz = 49'(p_c1z_ff) - 49'(p_s1x_ff) + 49'sd8192;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      tx_ff <= sum_tx[48:14];
      tz_ff <= sum_tz[48:14];
      ty_ff <= y1_ff;
   end

   // ---------------- stage 3: second-angle (Rx) products, vx ----------------
   logic               v3_ff;
   logic signed [50:0] q_c2y_ff, q_s2tz_ff, q_s2y_ff, q_c2tz_ff;
   logic signed [35:0] vx3_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
      q_c2y_ff  <= cos2_ff * ty_ff;
      q_s2tz_ff <= sin2_ff * tz_ff;
      q_s2y_ff  <= sin2_ff * ty_ff;
      q_c2tz_ff <= cos2_ff * tz_ff;
      vx3_ff    <= 36'(tx_ff) + 36'(offset_x_ff);
   end

   // ---------------- stage 4: round, add offsets ----------------
   logic               v4_ff;
   logic signed [35:0] vx4_ff;
   logic signed [38:0] vy4_ff, vz4_ff;
   logic signed [51:0] sum_vy, sum_vz;
   logic signed [37:0] rnd_vy, rnd_vz;

   assign sum_vy = 52'(q_c2y_ff) - 52'(q_s2tz_ff) + 52'sd8192;
   assign sum_vz = 52'(q_s2y_ff) + 52'(q_c2tz_ff) + 52'sd8192;
   assign rnd_vy = sum_vy[51:14];
   assign rnd_vz = sum_vz[51:14];

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else       v4_ff <= v3_ff;
      vx4_ff <= vx3_ff;
      vy4_ff <= 39'(rnd_vy) + 39'(offset_y_ff);
      vz4_ff <= 39'(rnd_vz) + 39'(offset_z_ff);
   end

   // ---------------- stage 5: magnitudes, signs, depth checks ----------------
   logic               v5_ff;
   logic        [38:0] ax5_ff, ay5_ff, az5_ff;
   side_type           side5_ff;
   logic signed [38:0] vx_ext;
   logic               dz_fits;
   side_type           side5_in;

   assign vx_ext  = 39'(vx4_ff);
   assign dz_fits = (&vz4_ff[38:31]) || !(|vz4_ff[38:31]);

   always_comb begin
      side5_in.zero   = (vz4_ff == '0);
      side5_in.neg_x  = vx_ext[38] ^ vz4_ff[38];
      side5_in.neg_y  = vy4_ff[38] ^ vz4_ff[38];
      side5_in.dz_sat = !dz_fits;
      if (dz_fits)        side5_in.dz = vz4_ff[31:0];
      else if (vz4_ff[38]) side5_in.dz = 32'h8000_0000;
      else                side5_in.dz = 32'h7FFF_FFFF;
   end

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else       v5_ff <= v4_ff;
      ax5_ff   <= vx_ext[38] ? 39'(-vx_ext) : 39'(vx_ext);
      ay5_ff   <= vy4_ff[38] ? 39'(-vy4_ff) : 39'(vy4_ff);
      az5_ff   <= vz4_ff[38] ? 39'(-vz4_ff) : 39'(vz4_ff);
      side5_ff <= side5_in;
   end

   // ---------------- stage 6: focal partial products ----------------
   logic        v6_ff;
   logic [43:0] plx_ff, ply_ff;
   logic [42:0] phx_ff, phy_ff;
   logic [38:0] az6_ff;
   side_type    side6_ff;

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else       v6_ff <= v5_ff;
      plx_ff   <= focal_ff * ax5_ff[19:0];
      phx_ff   <= focal_ff * ax5_ff[38:20];
      ply_ff   <= focal_ff * ay5_ff[19:0];
      phy_ff   <= focal_ff * ay5_ff[38:20];
      az6_ff   <= az5_ff;
      side6_ff <= side5_ff;
   end

   // ---------------- stage 7: numerators with half-divisor rounding ----------------
   logic                 v7_ff;
   logic [DIV_NUM_W-1:0] numx7_ff, numy7_ff;
   logic [DIV_DEN_W-1:0] den7_ff;
   side_type             side7_ff;

   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else       v7_ff <= v6_ff;
      numx7_ff <= (64'(phx_ff) << 20) + 64'(plx_ff) + 64'(az6_ff >> 1);
      numy7_ff <= (64'(phy_ff) << 20) + 64'(ply_ff) + 64'(az6_ff >> 1);
      den7_ff  <= az6_ff;
      side7_ff <= side6_ff;
   end

   // ---------------- divider ----------------
   logic                 dv_valid;
   logic [DIV_NUM_W-1:0] dv_qx, dv_qy;
   side_type             dv_side;

   vtsp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v7_ff),
      .in_num_x  (numx7_ff),
      .in_num_y  (numy7_ff),
      .in_den    (den7_ff),
      .in_side   (side7_ff),
      .out_valid (dv_valid),
      .out_q_x   (dv_qx),
      .out_q_y   (dv_qy),
      .out_side  (dv_side)
   );

   // ---------------- output: sign, center, saturate ----------------
   logic signed [65:0] full_x, full_y;
   logic               fit_x, fit_y;
   logic signed [31:0] sx_in, sy_in, dz_in;
   logic               flag_in;

   assign full_x = (dv_side.neg_x ? -66'(dv_qx) : 66'(dv_qx)) + CENTER_X;
   assign full_y = (dv_side.neg_y ? -66'(dv_qy) : 66'(dv_qy)) + CENTER_Y;
   assign fit_x  = (&full_x[65:31]) || !(|full_x[65:31]);
   assign fit_y  = (&full_y[65:31]) || !(|full_y[65:31]);

   always_comb begin
      if (dv_side.zero) begin
         sx_in   = 32'(CENTER_X);
         sy_in   = 32'(CENTER_Y);
         dz_in   = '0;
         flag_in = 1'b1;
      end else begin
         if (fit_x)          sx_in = full_x[31:0];
         else if (full_x[65]) sx_in = 32'h8000_0000;
         else                sx_in = 32'h7FFF_FFFF;
         if (fit_y)          sy_in = full_y[31:0];
         else if (full_y[65]) sy_in = 32'h8000_0000;
         else                sy_in = 32'h7FFF_FFFF;
         dz_in   = dv_side.dz;
         flag_in = !fit_x || !fit_y || dv_side.dz_sat;
      end
   end

   logic               rsp_valid_ff;
   logic signed [31:0] sx_ff, sy_ff, dz_ff;
   logic               flag_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= dv_valid;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      dz_ff   <= dz_in;
      flag_ff <= flag_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_screen_x     = sx_ff;
   assign rsp_screen_y     = sy_ff;
   assign rsp_view_depth   = dz_ff;
   assign rsp_invalid_flag = flag_ff;

   // ---------------- assertions ----------------
   `VTSP_ASSERT_IMPL(a_latency, start && !busy, ##LATENCY rsp_valid, "result beat missing")
   `VTSP_ASSERT_IMPL(a_zero_flag, rsp_valid && rsp_view_depth == '0, rsp_invalid_flag, "zero depth not flagged")
   `VTSP_ASSERT_IMPL(a_zero_center, rsp_valid && rsp_view_depth == '0, rsp_screen_x == 32'(CENTER_X) && rsp_screen_y == 32'(CENTER_Y), "zero depth not centered")
   `VTSP_ASSERT_NEXT(a_div_to_rsp, dv_valid, rsp_valid, "divider beat dropped")

endmodule
